### hw/rtl/hvlp_pkg.sv
package hvlp_pkg;

   localparam int FRACTION_BITS = 16;
   localparam int CORDIC_STAGES = 16;

   localparam int POS_W     = 33;
   localparam int CW        = 32;
   localparam int ANGLE_W   = 34;
   localparam int RADP_W    = 48;
   localparam int PROD_W    = CW + POS_W;
   localparam int SUM_W     = PROD_W + 2;
   localparam int MAG_W     = 34;
   localparam int NUM_W     = MAG_W + FRACTION_BITS;
   localparam int RATE_W    = NUM_W + 1;
   localparam int EXC_W     = RATE_W + 1;
   localparam int CLAMP_W   = 32 + FRACTION_BITS;
   localparam int HALF_W    = (CLAMP_W + 1) / 2;
   localparam int UPPER_W   = CLAMP_W - HALF_W;
   localparam int WEIGHT_W  = 24;
   localparam int LIMIT_W   = 31;
   localparam int BOUND_W   = 33;
   localparam int TOT_W     = WEIGHT_W + CLAMP_W + 1;
   localparam int DT_W      = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic signed [CW-1:0] CORDIC_START = 32'sd163008219;
   localparam logic signed [31:0]   PI_Q29       = 32'sd1686629713;

   localparam logic [29:0] ATAN_TABLE [30] = '{
      30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
      30'd21354465, 30'd10679838, 30'd5341269, 30'd2670163, 30'd1335087,
      30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
      30'd10431, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
      30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1
   };

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ROOT_WEIGHT_FORWARD = 3'd0,
      REG_ROOT_WEIGHT_LATERAL = 3'd1,
      REG_ROOT_WEIGHT_TURN    = 3'd2,
      REG_LIMIT_FORWARD       = 3'd3,
      REG_LIMIT_BACKWARD      = 3'd4,
      REG_LIMIT_LATERAL       = 3'd5,
      REG_LIMIT_TURN          = 3'd6,
      REG_PENALTY_MARGIN      = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [15:0] start_heading;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic signed [15:0] end_heading;
      logic [31:0]        step_time;
   } req_type;

   typedef struct packed {
      logic [31:0] penalty_forward;
      logic [31:0] penalty_lateral;
      logic [31:0] penalty_turn;
      logic        zero_step;
   } rsp_type;

   typedef struct packed {
      logic signed [POS_W-1:0]  dx;
      logic signed [POS_W-1:0]  dy;
      logic                     flip;
      logic signed [RADP_W-1:0] rad_prod;
      logic [DT_W-1:0]          dt;
      logic                     zero;
   } side_type;

   typedef struct packed {
      logic signed [CW-1:0]      x;
      logic signed [CW-1:0]      y;
      logic signed [ANGLE_W-1:0] z;
      side_type                  side;
   } cordic_stage_type;

   typedef struct packed {
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0]            neg;
      logic [DT_W-1:0]       dt;
      logic                  zero;
   } div_in_type;

   typedef struct packed {
      logic [2:0][NUM_W-1:0] quo;
      logic [2:0]            neg;
      logic                  zero;
   } div_out_type;

endpackage

### hw/rtl/hvlp_cordic.sv
module hvlp_cordic import hvlp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  cordic_stage_type cin,
   output logic             out_valid,
   output cordic_stage_type cout
);

   cordic_stage_type st_ff [CORDIC_STAGES];
   cordic_stage_type st_in [CORDIC_STAGES];
   cordic_stage_type cur   [CORDIC_STAGES+1];
   logic [CORDIC_STAGES-1:0] vld_ff;
   logic [CORDIC_STAGES:0]   vcur;

   assign cur[0]  = cin;
   assign vcur[0] = in_valid;

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
      logic signed [CW-1:0]      xs;
      logic signed [CW-1:0]      ys;
      logic signed [ANGLE_W-1:0] at;

      assign cur[k+1]  = st_ff[k];
      assign vcur[k+1] = vld_ff[k];
      assign xs = cur[k].x >>> k;
      assign ys = cur[k].y >>> k;
      assign at = ANGLE_W'(ATAN_TABLE[k]);

      always_comb begin
         st_in[k] = cur[k];
         if (cur[k].z >= 0) begin
            st_in[k].x = cur[k].x - ys;
            st_in[k].y = cur[k].y + xs;
            st_in[k].z = cur[k].z - at;
         end else begin
            st_in[k].x = cur[k].x + ys;
            st_in[k].y = cur[k].y - xs;
            st_in[k].z = cur[k].z + at;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vcur[CORDIC_STAGES-1:0];
      end
   end

   assign out_valid = vcur[CORDIC_STAGES];
   assign cout      = cur[CORDIC_STAGES];

endmodule

### hw/rtl/hvlp_divider.sv
module hvlp_divider import hvlp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  div_in_type  din,
   output logic        out_valid,
   output div_out_type dout
);

   typedef struct packed {
      logic [2:0][NUM_W-1:0] acc;
      logic [2:0][DT_W-1:0]  rem;
      logic [2:0]            neg;
      logic [DT_W-1:0]       dt;
      logic                  zero;
   } div_stage_type;

   div_stage_type st_ff [NUM_W];
   div_stage_type st_in [NUM_W];
   div_stage_type cur   [NUM_W+1];
   logic [NUM_W-1:0] vld_ff;
   logic [NUM_W:0]   vcur;

   always_comb begin
      cur[0].dt   = din.dt;
      cur[0].zero = din.zero;
      cur[0].neg  = din.neg;
      for (int l = 0; l < 3; l++) begin
         cur[0].acc[l] = {din.mag[l], {FRACTION_BITS{1'b0}}};
         cur[0].rem[l] = '0;
      end
   end
   assign vcur[0] = in_valid;

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      assign cur[k+1]  = st_ff[k];
      assign vcur[k+1] = vld_ff[k];

      always_comb begin
         logic [DT_W:0] trial;
         logic          ge;
         st_in[k] = cur[k];
         for (int l = 0; l < 3; l++) begin
            trial = {cur[k].rem[l], cur[k].acc[l][NUM_W-1]};
            ge    = trial >= {1'b0, cur[k].dt};
            st_in[k].rem[l] = ge ? DT_W'(trial - {1'b0, cur[k].dt}) : trial[DT_W-1:0];
            st_in[k].acc[l] = {cur[k].acc[l][NUM_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vcur[NUM_W-1:0];
      end
   end

   assign out_valid = vcur[NUM_W];
   assign dout.quo  = cur[NUM_W].acc;
   assign dout.neg  = cur[NUM_W].neg;
   assign dout.zero = cur[NUM_W].zero;

endmodule

### hw/rtl/holonomic_velocity_limit_penalty.sv
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_stall  req_type: two poses and a time step
// rsp      out        rsp_valid / rsp_stall  rsp_type: three penalties and zero_step
// csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// One item enters per cycle while no stalled result holds the pipeline; an item passes s0,
// the CORDIC stages, m1 to m3, the one-bit-per-stage restoring divider, e1-e3 and rsp_ff.
// Reset is synchronous; it clears the valid bits and loads the register defaults.
// A stalled result holds the whole pipeline; csr_ready is always high.
module holonomic_velocity_limit_penalty import hvlp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   typedef struct packed {
      logic signed [PROD_W-1:0] p_cdx;
      logic signed [PROD_W-1:0] p_sdy;
      logic signed [PROD_W-1:0] p_cdy;
      logic signed [PROD_W-1:0] p_sdx;
      logic signed [RADP_W-1:0] rad_prod;
      logic [DT_W-1:0]          dt;
      logic                     zero;
   } m1_type;

   typedef struct packed {
      logic [2:0][MAG_W:0] v;
      logic [DT_W-1:0]     dt;
      logic                zero;
   } m2_type;

   typedef struct packed {
      logic [2:0][RATE_W-1:0] rate;
      logic                   zero;
   } e1_type;

   typedef struct packed {
      logic [2:0][CLAMP_W-1:0] e;
      logic [2:0]              big;
      logic                    zero;
   } e2_type;

   typedef struct packed {
      logic [2:0][WEIGHT_W+UPPER_W-1:0] ph;
      logic [2:0][WEIGHT_W+HALF_W-1:0]  pl;
      logic [2:0]                       sat;
      logic                             zero;
   } e3_type;

   logic [WEIGHT_W-1:0] weight_ff [3];
   logic [LIMIT_W-1:0]  lim_fwd_ff, lim_back_ff, lim_lat_ff, lim_turn_ff, margin_ff;

   logic adv;
   logic s0_vld_ff, cor_vld, m1_vld_ff, m2_vld_ff, m3_vld_ff, div_vld;
   logic e1_vld_ff, e2_vld_ff, e3_vld_ff, rsp_valid_ff;

   cordic_stage_type s0_ff, s0_in, cor_out;
   m1_type      m1_ff, m1_in;
   m2_type      m2_ff, m2_in;
   div_in_type  m3_ff, m3_in;
   div_out_type div_out;
   e1_type      e1_ff, e1_in;
   e2_type      e2_ff, e2_in;
   e3_type      e3_ff, e3_in;
   rsp_type     rsp_ff, rsp_in;

   logic signed [16:0]         head;
   logic                       flip;
   logic signed [15:0]         dhead;
   logic signed [CW-1:0]       cos_v, sin_v;
   logic signed [BOUND_W-1:0]  lo [3];
   logic signed [BOUND_W-1:0]  hi [3];

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff[0] <= WEIGHT_W'(65536);
         weight_ff[1] <= WEIGHT_W'(65536);
         weight_ff[2] <= WEIGHT_W'(65536);
         lim_fwd_ff   <= LIMIT_W'(26214);
         lim_back_ff  <= LIMIT_W'(13107);
         lim_lat_ff   <= '0;
         lim_turn_ff  <= LIMIT_W'(19661);
         margin_ff    <= LIMIT_W'(6554);
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            REG_ROOT_WEIGHT_FORWARD: weight_ff[0] <= csr_data[WEIGHT_W-1:0];
            REG_ROOT_WEIGHT_LATERAL: weight_ff[1] <= csr_data[WEIGHT_W-1:0];
            REG_ROOT_WEIGHT_TURN:    weight_ff[2] <= csr_data[WEIGHT_W-1:0];
            REG_LIMIT_FORWARD:       lim_fwd_ff   <= csr_data[LIMIT_W-1:0];
            REG_LIMIT_BACKWARD:      lim_back_ff  <= csr_data[LIMIT_W-1:0];
            REG_LIMIT_LATERAL:       lim_lat_ff   <= csr_data[LIMIT_W-1:0];
            REG_LIMIT_TURN:          lim_turn_ff  <= csr_data[LIMIT_W-1:0];
            REG_PENALTY_MARGIN:      margin_ff    <= csr_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      lo[0] = $signed({2'b0, margin_ff}) - $signed({2'b0, lim_back_ff});
      hi[0] = $signed({2'b0, lim_fwd_ff}) - $signed({2'b0, margin_ff});
      lo[1] = -$signed({2'b0, lim_lat_ff});
      hi[1] = $signed({2'b0, lim_lat_ff});
      lo[2] = $signed({2'b0, margin_ff}) - $signed({2'b0, lim_turn_ff});
      hi[2] = $signed({2'b0, lim_turn_ff}) - $signed({2'b0, margin_ff});
   end

   // input stage: differences, quadrant fold, heading delta scaled by pi
   always_comb begin
      head  = 17'(req_data.start_heading);
      flip  = 1'b0;
      if (head >= 17'sd16384) begin
         head = head - 17'sd32768;
         flip = 1'b1;
      end else if (head < -17'sd16384) begin
         head = head + 17'sd32768;
         flip = 1'b1;
      end
      dhead = req_data.end_heading - req_data.start_heading;
      s0_in.x = CORDIC_START;
      s0_in.y = '0;
      s0_in.z = ANGLE_W'(head) <<< 16;
      s0_in.side.dx = POS_W'(req_data.end_x) - POS_W'(req_data.start_x);
      s0_in.side.dy = POS_W'(req_data.end_y) - POS_W'(req_data.start_y);
      s0_in.side.flip = flip;
      s0_in.side.rad_prod = RADP_W'(dhead) * RADP_W'(PI_Q29);
      s0_in.side.dt = req_data.step_time;
      s0_in.side.zero = req_data.step_time == '0;
   end

   hvlp_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s0_vld_ff),
      .cin       (s0_ff),
      .out_valid (cor_vld),
      .cout      (cor_out)
   );

   always_comb begin
      cos_v = cor_out.side.flip ? -cor_out.x : cor_out.x;
      sin_v = cor_out.side.flip ? -cor_out.y : cor_out.y;
      m1_in.p_cdx = PROD_W'(cos_v) * PROD_W'(cor_out.side.dx);
      m1_in.p_sdy = PROD_W'(sin_v) * PROD_W'(cor_out.side.dy);
      m1_in.p_cdy = PROD_W'(cos_v) * PROD_W'(cor_out.side.dy);
      m1_in.p_sdx = PROD_W'(sin_v) * PROD_W'(cor_out.side.dx);
      m1_in.rad_prod = cor_out.side.rad_prod;
      m1_in.dt = cor_out.side.dt;
      m1_in.zero = cor_out.side.zero;
   end

   always_comb begin
      logic signed [SUM_W-1:0]  fsum;
      logic signed [SUM_W-1:0]  lsum;
      logic signed [RADP_W:0]   rsum;
      logic signed [SUM_W-1:0]  fsh;
      logic signed [SUM_W-1:0]  lsh;
      logic signed [RADP_W:0]   rsh;
      fsum = SUM_W'(m1_ff.p_cdx) + SUM_W'(m1_ff.p_sdy) + (SUM_W'(1) <<< 27);
      lsum = SUM_W'(m1_ff.p_cdy) - SUM_W'(m1_ff.p_sdx) + (SUM_W'(1) <<< 27);
      rsum = (RADP_W+1)'(m1_ff.rad_prod) + ((RADP_W+1)'(1) <<< (43 - FRACTION_BITS));
      fsh = fsum >>> 28;
      lsh = lsum >>> 28;
      rsh = rsum >>> (44 - FRACTION_BITS);
      m2_in.v[0] = fsh[MAG_W:0];
      m2_in.v[1] = lsh[MAG_W:0];
      m2_in.v[2] = rsh[MAG_W:0];
      m2_in.dt = m1_ff.dt;
      m2_in.zero = m1_ff.zero;
   end

   always_comb begin
      logic [MAG_W:0] neg_v;
      m3_in.dt = m2_ff.dt;
      m3_in.zero = m2_ff.zero;
      for (int l = 0; l < 3; l++) begin
         neg_v = -m2_ff.v[l];
         m3_in.neg[l] = m2_ff.v[l][MAG_W];
         m3_in.mag[l] = m2_ff.v[l][MAG_W] ? neg_v[MAG_W-1:0] : m2_ff.v[l][MAG_W-1:0];
      end
   end

   hvlp_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (m3_vld_ff),
      .din       (m3_ff),
      .out_valid (div_vld),
      .dout      (div_out)
   );

   always_comb begin
      e1_in.zero = div_out.zero;
      for (int l = 0; l < 3; l++) begin
         e1_in.rate[l] = div_out.neg[l] ? -{1'b0, div_out.quo[l]} : {1'b0, div_out.quo[l]};
      end
   end

   // upper bound is tested first so an inverted window keeps the crossed bound
   always_comb begin
      logic signed [EXC_W-1:0] dh;
      logic signed [EXC_W-1:0] dl;
      logic [EXC_W-2:0]        e;
      e2_in.zero = e1_ff.zero;
      for (int l = 0; l < 3; l++) begin
         dh = EXC_W'($signed(e1_ff.rate[l])) - EXC_W'(hi[l]);
         dl = EXC_W'(lo[l]) - EXC_W'($signed(e1_ff.rate[l]));
         if (dh > 0) begin
            e = dh[EXC_W-2:0];
         end else if (dl > 0) begin
            e = dl[EXC_W-2:0];
         end else begin
            e = '0;
         end
         e2_in.big[l] = |e[EXC_W-2:CLAMP_W];
         e2_in.e[l]   = e[CLAMP_W-1:0];
      end
   end

   always_comb begin
      e3_in.zero = e2_ff.zero;
      for (int l = 0; l < 3; l++) begin
         e3_in.pl[l] = (WEIGHT_W+HALF_W)'(weight_ff[l]) *
                       (WEIGHT_W+HALF_W)'(e2_ff.e[l][HALF_W-1:0]);
         e3_in.ph[l] = (WEIGHT_W+UPPER_W)'(weight_ff[l]) *
                       (WEIGHT_W+UPPER_W)'(e2_ff.e[l][CLAMP_W-1:HALF_W]);
         e3_in.sat[l] = e2_ff.big[l] && (weight_ff[l] != '0);
      end
   end

   always_comb begin
      logic [TOT_W-1:0] tot;
      logic [31:0]      pen [3];
      for (int l = 0; l < 3; l++) begin
         tot = (TOT_W'(e3_ff.ph[l]) << HALF_W) + TOT_W'(e3_ff.pl[l]);
         if (e3_ff.zero || e3_ff.sat[l] || (|tot[TOT_W-1:32+FRACTION_BITS])) begin
            pen[l] = '1;
         end else begin
            pen[l] = tot[31+FRACTION_BITS:FRACTION_BITS];
         end
      end
      rsp_in.penalty_forward = pen[0];
      rsp_in.penalty_lateral = pen[1];
      rsp_in.penalty_turn    = pen[2];
      rsp_in.zero_step       = e3_ff.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff    <= 1'b0;
         m1_vld_ff    <= 1'b0;
         m2_vld_ff    <= 1'b0;
         m3_vld_ff    <= 1'b0;
         e1_vld_ff    <= 1'b0;
         e2_vld_ff    <= 1'b0;
         e3_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff    <= req_valid;
         m1_vld_ff    <= cor_vld;
         m2_vld_ff    <= m1_vld_ff;
         m3_vld_ff    <= m2_vld_ff;
         e1_vld_ff    <= div_vld;
         e2_vld_ff    <= e1_vld_ff;
         e3_vld_ff    <= e2_vld_ff;
         rsp_valid_ff <= e3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ff  <= s0_in;
         m1_ff  <= m1_in;
         m2_ff  <= m2_in;
         m3_ff  <= m3_in;
         e1_ff  <= e1_in;
         e2_ff  <= e2_in;
         e3_ff  <= e3_in;
         rsp_ff <= rsp_in;
      end
   end

endmodule
